// ----- src/febfp_pkg.sv -----
// ----------------------------------------------------------------------------
// febfp_pkg: shared types and constants
// Transaction structs, op and status codes, sizes of the extent table and
// of the remainder unit.
// ----------------------------------------------------------------------------
package febfp_pkg;

    localparam int MAX_EXTENTS = 16;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ADDR_W      = 48;
    localparam int SECTOR_B    = 512;

    // cylinder size is at most 255 * 63 * 512, which fits 23 bits
    localparam int CYL_W       = 23;
    localparam int MOD_DIG     = 4;                // dividend bits per cycle
    localparam int DVD_W       = 52;               // >= 49, multiple of MOD_DIG
    localparam int MOD_STEPS   = DVD_W / MOD_DIG;
    localparam int STEP_W      = $clog2(MOD_STEPS);

    localparam int ENTRY_W     = 2 * ADDR_W + 1;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_PLACE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] CFG_HEADS   = 2'd0;
    localparam logic [1:0] CFG_SECTORS = 2'd1;
    localparam logic [1:0] CFG_DOS     = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] ext_start;
        logic [ADDR_W-1:0] ext_end;
        logic              ext_logical;
        logic [ADDR_W-1:0] size_wanted;
        logic              want_logical;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] place_start;
        logic [ADDR_W-1:0] place_end;
        logic [ADDR_W-1:0] free_total;
        logic [ADDR_W-1:0] disk_span;
    } out_t;

    typedef struct packed {
        logic              logical;
        logic [ADDR_W-1:0] finish;
        logic [ADDR_W-1:0] begin_b;
    } entry_t;

endpackage

// ----- src/free_extent_best_fit_placer_core.sv -----
// ----------------------------------------------------------------------------
// free_extent_best_fit_placer_core: best-fit partition placer
// Clear, add and unused ops are answered straight from idle; the result is registered.
// A place takes a remainder of the size, then per stored extent a table read,
// a remainder and an evaluation, then a remainder of the chosen start, all on
// the shared remainder unit; the extent table has one write and one read port.
// One transaction at a time; a new one is taken once the result is consumed.
// Reset (async, active low) empties the table, zeroes the sums and loads
// heads 255, sectors 63, msdos rules on.
// ----------------------------------------------------------------------------
module free_extent_best_fit_placer_core
    import febfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_MODA_GO = 10'b0000000010,
        S_MODA    = 10'b0000000100,
        S_SCAN_RD = 10'b0000001000,
        S_SCAN_GO = 10'b0000010000,
        S_SCAN_MD = 10'b0000100000,
        S_EVAL    = 10'b0001000000,
        S_FIN     = 10'b0010000000,
        S_FIN_GO  = 10'b0100000000,
        S_FIN_MD  = 10'b1000000000
    } state_t;

    state_t            state_reg;
    logic [7:0]        heads_reg;
    logic [5:0]        sectors_reg;
    logic              dos_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] free_sum_reg;
    logic [ADDR_W-1:0] span_reg;
    logic [1:0]        status_reg;
    logic [ADDR_W-1:0] place_start_reg;
    logic [ADDR_W-1:0] place_end_reg;
    logic              out_valid_reg;

    logic [ADDR_W-1:0] alloc_reg;
    logic              logical_reg;
    logic              dos_q_reg;
    logic [CYL_W-1:0]  cyl_reg;
    logic [CYL_W-1:0]  extra_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] best_size_reg;
    logic [ADDR_W+1:0] best_need_reg;
    logic [ADDR_W-1:0] best_begin_reg;
    logic [ADDR_W-1:0] cand_size_reg;
    logic [ADDR_W+1:0] cand_need_reg;
    logic [ADDR_W-1:0] cand_begin_reg;
    logic              cand_ok_reg;
    logic [ADDR_W:0]   ps_reg;

    logic              accept;
    entry_t            wr_entry;
    entry_t            rd_entry;
    logic              ram_we;
    logic              ram_re;
    logic [DVD_W-1:0]  mod_dvd;
    logic              mod_start;
    logic              mod_done;
    logic [CYL_W-1:0]  mod_rem;

    // add path
    logic [ADDR_W-1:0] add_s;
    logic [ADDR_W:0]   add_sum;

    // geometry
    logic [7:0]        h_eff;
    logic [5:0]        s_eff;
    logic [13:0]       hs;

    // candidate evaluation
    logic [ADDR_W-1:0] ev_size;
    logic [ADDR_W+1:0] ev_need;
    logic              ev_ok;
    logic [ADDR_W+2:0] pe_full;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    // sums are final when the result is raised; they do not move meanwhile
    assign out_data  = {status_reg, place_start_reg, place_end_reg, free_sum_reg, span_reg};

    assign add_s   = (in_data.ext_start == '0) ? ADDR_W'(SECTOR_B) : in_data.ext_start;
    assign add_sum = {1'b0, free_sum_reg} + {1'b0, in_data.ext_end - add_s};

    assign h_eff = (heads_reg == '0) ? 8'd1 : heads_reg;
    assign s_eff = (sectors_reg == '0) ? 6'd1 : sectors_reg;
    assign hs    = h_eff * s_eff;

    assign wr_entry.logical = in_data.ext_logical;
    assign wr_entry.finish  = in_data.ext_end;
    assign wr_entry.begin_b = add_s;
    assign ram_we = accept && (in_data.op == OP_ADD)
                    && (count_reg < CNT_W'(MAX_EXTENTS));
    assign ram_re = (state_reg == S_SCAN_RD) && (idx_reg != count_reg);

    febfp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_EXTENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    always_comb
    begin
        mod_start = 1'b0;
        mod_dvd   = '0;
        case (state_reg)
            S_MODA_GO:
            begin
                mod_start = 1'b1;
                mod_dvd   = DVD_W'(alloc_reg);
            end
            S_SCAN_GO:
            begin
                mod_start = 1'b1;
                mod_dvd   = DVD_W'(rd_entry.begin_b);
            end
            S_FIN_GO:
            begin
                mod_start = 1'b1;
                mod_dvd   = DVD_W'(ps_reg);
            end
            default:
            begin
                mod_start = 1'b0;
            end
        endcase
    end

    febfp_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dvd),
        .divisor  (cyl_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // need and usable size of the extent just read; mod_rem holds begin % cyl
    always_comb
    begin
        logic [ADDR_W:0] diff;
        diff    = {1'b0, rd_entry.finish} - {1'b0, rd_entry.begin_b};
        ev_size = diff[ADDR_W-1:0];
        ev_ok   = !diff[ADDR_W] && (rd_entry.logical == logical_reg);
        ev_need = {2'b00, alloc_reg};
        if (dos_q_reg)
        begin
            ev_need = ev_need + (ADDR_W+2)'(extra_reg)
                      + ((mod_rem > extra_reg) ? (ADDR_W+2)'(cyl_reg) : '0);
            if (logical_reg)
            begin
                if (ev_size < ADDR_W'(SECTOR_B))
                begin
                    ev_ok = 1'b0;
                end
                ev_size = ev_size - ADDR_W'(SECTOR_B);
            end
        end
    end

    assign pe_full = (ADDR_W+3)'(ps_reg) + (ADDR_W+3)'(best_need_reg)
                     - (dos_q_reg ? (ADDR_W+3)'(mod_rem) : '0) - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            heads_reg     <= 8'd255;
            sectors_reg   <= 6'd63;
            dos_reg       <= 1'b1;
            count_reg     <= '0;
            free_sum_reg  <= '0;
            span_reg      <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEADS:   heads_reg   <= cfg_wdata;
                    CFG_SECTORS: sectors_reg <= cfg_wdata[5:0];
                    CFG_DOS:     dos_reg     <= cfg_wdata[0];
                    default:     heads_reg   <= heads_reg;
                endcase
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_data.op)
                            OP_CLEAR:
                            begin
                                count_reg     <= '0;
                                free_sum_reg  <= '0;
                                span_reg      <= '0;
                                out_valid_reg <= 1'b1;
                            end
                            OP_ADD:
                            begin
                                if (count_reg < CNT_W'(MAX_EXTENTS))
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    if (in_data.ext_end > add_s)
                                    begin
                                        free_sum_reg <= add_sum[ADDR_W] ? '1
                                                        : add_sum[ADDR_W-1:0];
                                    end
                                    if (in_data.ext_end > span_reg)
                                    begin
                                        span_reg <= in_data.ext_end;
                                    end
                                end
                                out_valid_reg <= 1'b1;
                            end
                            OP_PLACE:
                            begin
                                state_reg <= S_MODA_GO;
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_MODA_GO:
                begin
                    state_reg <= S_MODA;
                end
                S_MODA:
                begin
                    if (mod_done)
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= (idx_reg == count_reg) ? S_FIN : S_SCAN_GO;
                end
                S_SCAN_GO:
                begin
                    state_reg <= S_SCAN_MD;
                end
                S_SCAN_MD:
                begin
                    if (mod_done)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (cand_ok_reg && ({2'b00, cand_size_reg} > cand_need_reg)
                        && (!found_reg || cand_size_reg < best_size_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SCAN_RD;
                end
                S_FIN:
                begin
                    if (found_reg)
                    begin
                        state_reg <= S_FIN_GO;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_FIN_GO:
                begin
                    state_reg <= S_FIN_MD;
                end
                S_FIN_MD:
                begin
                    if (mod_done)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                alloc_reg   <= in_data.size_wanted;
                logical_reg <= dos_reg && in_data.want_logical;
                dos_q_reg   <= dos_reg;
                cyl_reg     <= CYL_W'({hs, 9'd0});
                if (accept)
                begin
                    place_start_reg <= '0;
                    place_end_reg   <= '0;
                    status_reg      <= (in_data.op == OP_ADD
                                        && count_reg >= CNT_W'(MAX_EXTENTS))
                                       ? ST_FULL : ST_OK;
                end
            end
            S_MODA:
            begin
                extra_reg <= cyl_reg - mod_rem;
            end
            S_SCAN_MD:
            begin
                cand_size_reg  <= ev_size;
                cand_need_reg  <= ev_need;
                cand_ok_reg    <= ev_ok;
                cand_begin_reg <= rd_entry.begin_b;
            end
            S_EVAL:
            begin
                if (cand_ok_reg && ({2'b00, cand_size_reg} > cand_need_reg)
                    && (!found_reg || cand_size_reg < best_size_reg))
                begin
                    best_size_reg  <= cand_size_reg;
                    best_need_reg  <= cand_need_reg;
                    best_begin_reg <= cand_begin_reg;
                end
            end
            S_FIN:
            begin
                ps_reg <= {1'b0, best_begin_reg}
                          + (logical_reg ? (ADDR_W+1)'(SECTOR_B) : '0);
                status_reg      <= ST_NOFIT;
                place_start_reg <= '0;
                place_end_reg   <= '0;
            end
            S_FIN_MD:
            begin
                status_reg      <= ST_OK;
                place_start_reg <= ps_reg[ADDR_W-1:0];
                place_end_reg   <= pe_full[ADDR_W-1:0];
            end
            default:
            begin
                cand_ok_reg <= cand_ok_reg;
            end
        endcase
    end

endmodule

// ----- src/febfp_ram.sv -----
// ----------------------------------------------------------------------------
// febfp_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module febfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/febfp_mod.sv -----
// ----------------------------------------------------------------------------
// febfp_mod: iterative remainder unit
// Restoring remainder by the cylinder size, MOD_DIG dividend bits a cycle.
// done pulses one cycle with rem valid until the next start.
// ----------------------------------------------------------------------------
module febfp_mod
    import febfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [CYL_W-1:0] divisor,
    output logic             done,
    output logic [CYL_W-1:0] rem
);

    logic [DVD_W-1:0]  dvd_reg;
    logic [CYL_W-1:0]  dvs_reg;
    logic [CYL_W-1:0]  rem_reg;
    logic [CYL_W-1:0]  rem_next;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    always_comb
    begin
        logic [CYL_W:0] r;
        r = {1'b0, rem_reg};
        for (int k = 0; k < MOD_DIG; k++)
        begin
            r = {r[CYL_W-1:0], dvd_reg[DVD_W-1-k]};
            if (r >= {1'b0, dvs_reg})
            begin
                r = r - {1'b0, dvs_reg};
            end
        end
        rem_next = r[CYL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(MOD_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << MOD_DIG;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: best-fit partition placer check
// Drives clear, add, place and unused-op transactions through the handshake, predicts
// every result from a local model of the extent table and compares fields.
// ----------------------------------------------------------------------------
module testbench;
    import febfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0]  OP_NONE = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_HEADS;
    logic [7:0] cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_t        in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_t       out_data;

    always #1 clk = ~clk;

    free_extent_best_fit_placer_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // local copy of the table and settings
    logic [47:0] tbl_begin [MAX_EXTENTS];
    logic [47:0] tbl_finish[MAX_EXTENTS];
    logic        tbl_logical[MAX_EXTENTS];
    int          tbl_count;
    logic [47:0] sum_free;
    logic [47:0] span_top;
    logic [7:0]  geo_heads;
    logic [5:0]  geo_sectors;
    logic        msdos;

    in_t  pending_items[$];
    out_t placements_due[$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_cycles = 0;

    function automatic out_t placer_predict(in_t it);
        out_t r;
        logic [63:0] cyl, extra, alloc, need, sz, best_size, best_need, ps, pe, s, e;
        logic [64:0] acc;
        bit dos, lg, found;
        int best;
        r = '0;
        case (it.op)
            OP_CLEAR:
            begin
                tbl_count = 0;
                sum_free = '0;
                span_top = '0;
            end
            OP_ADD:
            begin
                if (tbl_count >= MAX_EXTENTS)
                    r.status = ST_FULL;
                else
                begin
                    s = 64'(it.ext_start);
                    e = 64'(it.ext_end);
                    if (s == 0) s = 64'(SECTOR_B);
                    tbl_begin[tbl_count] = s[47:0];
                    tbl_finish[tbl_count] = e[47:0];
                    tbl_logical[tbl_count] = it.ext_logical;
                    tbl_count++;
                    if (e > s)
                    begin
                        acc = {17'd0, sum_free} + 65'(e - s);
                        sum_free = (acc > 65'(MASK48)) ? MASK48 : acc[47:0];
                    end
                    if (e[47:0] > span_top) span_top = e[47:0];
                end
            end
            OP_PLACE:
            begin
                dos = msdos;
                lg = dos && it.want_logical;
                alloc = 64'(it.size_wanted);
                cyl = 64'(geo_heads == 0 ? 1 : geo_heads)
                    * 64'(geo_sectors == 0 ? 1 : geo_sectors) * 64'(SECTOR_B);
                extra = cyl - (alloc % cyl);
                found = 0;
                best = 0;
                best_size = 0;
                best_need = 0;
                for (int i = 0; i < tbl_count; i++)
                begin
                    s = 64'(tbl_begin[i]);
                    e = 64'(tbl_finish[i]);
                    need = alloc;
                    if (e < s) continue;
                    sz = e - s;
                    if (tbl_logical[i] != lg) continue;
                    if (dos)
                    begin
                        need += extra;
                        if ((s % cyl) > extra) need += cyl;
                        if (lg)
                        begin
                            if (sz < 64'(SECTOR_B)) continue;
                            sz -= 64'(SECTOR_B);
                        end
                    end
                    if (sz > need && (!found || sz < best_size))
                    begin
                        found = 1;
                        best = i;
                        best_size = sz;
                        best_need = need;
                    end
                end
                if (!found)
                    r.status = ST_NOFIT;
                else
                begin
                    ps = 64'(tbl_begin[best]);
                    if (lg) ps += 64'(SECTOR_B);
                    pe = ps + best_need;
                    if (dos) pe -= ps % cyl;
                    pe -= 64'd1;
                    r.place_start = ps[47:0];
                    r.place_end = pe[47:0];
                end
            end
            default: ;
        endcase
        r.free_total = sum_free;
        r.disk_span = span_top;
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // predict on acceptance, so config changes only land between phases
    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            placements_due.push_back(placer_predict(in_data));

    // receiver and monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_valid && out_ready)
            begin
                if (placements_due.size() == 0)
                begin
                    $error("result with no transaction pending");
                    errors++;
                end
                else
                begin
                    out_t x;
                    x = placements_due.pop_front();
                    if (x.status !== out_data.status)
                    begin
                        $error("status exp %0d got %0d", x.status, out_data.status);
                        errors++;
                    end
                    if (x.place_start !== out_data.place_start)
                    begin
                        $error("place_start exp %h got %h", x.place_start,
                               out_data.place_start);
                        errors++;
                    end
                    if (x.place_end !== out_data.place_end)
                    begin
                        $error("place_end exp %h got %h", x.place_end, out_data.place_end);
                        errors++;
                    end
                    if (x.free_total !== out_data.free_total)
                    begin
                        $error("free_total exp %h got %h", x.free_total,
                               out_data.free_total);
                        errors++;
                    end
                    if (x.disk_span !== out_data.disk_span)
                    begin
                        $error("disk_span exp %h got %h", x.disk_span, out_data.disk_span);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic logic [47:0] rnd48();
        logic [47:0] v;
        case ($urandom_range(3))
            0: v = 48'({$urandom, $urandom});
            1: v = 48'($urandom_range(70_000_000));
            2: v = MASK48 - 48'($urandom_range(4096));
            default: v = 48'($urandom_range(1024));
        endcase
        return v;
    endfunction

    function automatic in_t make_item(logic [1:0] op, logic [47:0] s, logic [47:0] e,
                                      logic el, logic [47:0] sz, logic wl);
        in_t it;
        it.op = op;
        it.ext_start = s;
        it.ext_end = e;
        it.ext_logical = el;
        it.size_wanted = sz;
        it.want_logical = wl;
        return it;
    endfunction

    task automatic queue_random(int n);
        logic [47:0] b;
        for (int k = 0; k < n; k++)
        begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 4)
                pending_items.push_back(make_item(OP_CLEAR, rnd48(), rnd48(),
                    1'($urandom), rnd48(), 1'($urandom)));
            else if (pick < 6)
                pending_items.push_back(make_item(OP_NONE, rnd48(), rnd48(),
                    1'($urandom), rnd48(), 1'($urandom)));
            else if (pick < 50)
            begin
                // mostly well-formed extents, some random
                b = ($urandom_range(9) == 0) ? 48'd0 : rnd48();
                if ($urandom_range(4) == 0)
                    pending_items.push_back(make_item(OP_ADD, b, rnd48(),
                        1'($urandom), rnd48(), 1'($urandom)));
                else
                    pending_items.push_back(make_item(OP_ADD, b,
                        b + 48'($urandom_range(200_000_000)), 1'($urandom), rnd48(),
                        1'($urandom)));
            end
            else
                pending_items.push_back(make_item(OP_PLACE, rnd48(), rnd48(), 1'($urandom),
                    ($urandom_range(3) == 0) ? rnd48() : 48'($urandom_range(100_000_000)),
                    1'($urandom)));
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || placements_due.size() > 0)
            @(posedge clk);
        repeat (320) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HEADS: geo_heads = val;
            CFG_SECTORS: geo_sectors = val[5:0];
            default: msdos = val[0];
        endcase
    endtask

    initial
    begin
        tbl_count = 0;
        sum_free = '0;
        span_top = '0;
        geo_heads = 8'd255;
        geo_sectors = 6'd63;
        msdos = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, start-0 fix, reversed, tiny logical, saturation, full
        pending_items.push_back(make_item(OP_PLACE, 48'd0, 48'd0, 1'b0, 48'd0, 1'b0));
        pending_items.push_back(make_item(OP_ADD, 48'd0, 48'd100_000_000, 1'b0, 48'd0,
            1'b0));
        pending_items.push_back(make_item(OP_ADD, 48'd5000, 48'd4000, 1'b0, 48'd0, 1'b0));
        pending_items.push_back(make_item(OP_ADD, 48'd200_000_000, 48'd200_000_300, 1'b1,
            48'd0, 1'b1));
        pending_items.push_back(make_item(OP_ADD, 48'd300_000_000, 48'd900_000_000, 1'b1,
            48'd0, 1'b0));
        pending_items.push_back(make_item(OP_ADD, 48'd1, MASK48, 1'b0, MASK48, 1'b1));
        pending_items.push_back(make_item(OP_ADD, 48'd2, MASK48, 1'b1, 48'd0, 1'b0));
        pending_items.push_back(make_item(OP_PLACE, 48'd0, 48'd0, 1'b0, 48'd1_000_000,
            1'b0));
        pending_items.push_back(make_item(OP_PLACE, 48'd0, 48'd0, 1'b0, 48'd1_000_000,
            1'b1));
        pending_items.push_back(make_item(OP_PLACE, 48'd0, 48'd0, 1'b0, MASK48, 1'b0));
        pending_items.push_back(make_item(OP_PLACE, 48'd0, 48'd0, 1'b0, 48'd0, 1'b1));
        pending_items.push_back(make_item(OP_NONE, MASK48, MASK48, 1'b1, MASK48, 1'b1));
        for (int k = 0; k < 11; k++)
            pending_items.push_back(make_item(OP_ADD, 48'd4096 * 48'(k),
                48'd9_000_000 * 48'(k), k[0], 48'd0, 1'b0));
        pending_items.push_back(make_item(OP_PLACE, 48'd0, 48'd0, 1'b0, 48'd512, 1'b1));
        pending_items.push_back(make_item(OP_CLEAR, MASK48, MASK48, 1'b1, MASK48, 1'b1));
        drain();

        send_idle_pct = 6;
        recv_idle_pct = 80;
        queue_random(300);
        drain();
        set_reg(CFG_HEADS, 8'd1);
        set_reg(CFG_SECTORS, 8'd1);
        set_reg(CFG_DOS, 8'd0);
        queue_random(200);
        drain();

        send_idle_pct = 80;
        recv_idle_pct = 6;
        set_reg(CFG_HEADS, 8'd0);
        set_reg(CFG_SECTORS, 8'd0);
        set_reg(CFG_DOS, 8'd1);
        queue_random(250);
        drain();
        set_reg(CFG_HEADS, 8'd16);
        set_reg(CFG_SECTORS, 8'd32);
        queue_random(150);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_reg(CFG_HEADS, 8'd255);
        set_reg(CFG_SECTORS, 8'd63);
        queue_random(200);
        hold_cycles = 400;
        drain();
        set_reg(CFG_DOS, 8'd0);
        queue_random(180);
        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
